// ===== src/ncr_pkg.sv =====
`default_nettype none
package ncr_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int CODE_W = 31;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_KEEP_BUILTIN = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_AMP = 1'b1;

	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_X = 8'h78;
	localparam logic [7:0] CH_SEMI = 8'h3b;

	// One request for the back end: the pieces of output in the order they are written.
	typedef struct packed {
		logic amp_plain;
		logic amp;
		logic hash;
		logic hexx;
		logic ref_en;
		logic ref_hex;
		logic [CODE_W-1:0] code;
		logic fresh_en;
		logic [7:0] fresh;
	} cmd_t;

endpackage
`default_nettype wire

// ===== src/ncr_front.sv =====
`default_nettype none
module ncr_front import ncr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire logic [7:0] in_byte,
	input wire logic end_of_stream,
	output logic push,
	output cmd_t push_cmd
);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_AMP,
		MODE_HASH,
		MODE_HEXX,
		MODE_DEC,
		MODE_HEX
	} mode_t;

	mode_t mode_q, mode_d;
	logic [CODE_W-1:0] acc_q, acc_d;
	cmd_t cmd;

	logic is_digit, is_upper, is_lower, is_alnum, is_hex;
	logic [3:0] hex_val;
	logic [34:0] prod;
	logic [35:0] sum;
	logic [CODE_W-1:0] acc_next;

	always_comb begin
		is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
		is_upper = (in_byte >= 8'h41) && (in_byte <= 8'h5a);
		is_lower = (in_byte >= 8'h61) && (in_byte <= 8'h7a);
		is_alnum = is_digit || is_upper || is_lower;
		is_hex = is_digit || ((in_byte >= 8'h41) && (in_byte <= 8'h46))
			|| ((in_byte >= 8'h61) && (in_byte <= 8'h66));
		hex_val = is_digit ? in_byte[3:0] : in_byte[3:0] + 4'd9;
	end

	always_comb begin
		if (mode_q == MODE_HEX) begin
			prod = {acc_q, 4'b0000};
		end else begin
			prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
		end
		sum = {1'b0, prod} + {32'd0, hex_val};
		acc_next = (sum[35:31] != 5'd0) ? {CODE_W{1'b1}} : sum[CODE_W-1:0];
	end

	always_comb begin
		logic do_fresh;
		do_fresh = 1'b0;
		cmd = '0;
		mode_d = mode_q;
		acc_d = acc_q;
		if (end_of_stream) begin
			case (mode_q)
				MODE_AMP: begin
					cmd.amp = 1'b1;
				end
				MODE_HASH: begin
					cmd.amp = 1'b1;
					cmd.hash = 1'b1;
				end
				MODE_HEXX: begin
					cmd.amp = 1'b1;
					cmd.hash = 1'b1;
					cmd.hexx = 1'b1;
				end
				MODE_DEC, MODE_HEX: begin
					cmd.ref_en = 1'b1;
					cmd.ref_hex = (mode_q == MODE_HEX);
					cmd.code = acc_q;
				end
				default: begin
				end
			endcase
			mode_d = MODE_IDLE;
			acc_d = '0;
		end else begin
			case (mode_q)
				MODE_AMP: begin
					if (in_byte == CH_HASH) begin
						mode_d = MODE_HASH;
					end else begin
						cmd.amp_plain = is_alnum;
						cmd.amp = !is_alnum;
						mode_d = MODE_IDLE;
						do_fresh = 1'b1;
					end
				end
				MODE_HASH: begin
					if (is_digit) begin
						acc_d = {27'd0, in_byte[3:0]};
						mode_d = MODE_DEC;
					end else if (in_byte == CH_X) begin
						mode_d = MODE_HEXX;
					end else begin
						cmd.amp = 1'b1;
						cmd.hash = 1'b1;
						mode_d = MODE_IDLE;
						do_fresh = 1'b1;
					end
				end
				MODE_HEXX: begin
					if (is_hex) begin
						acc_d = {27'd0, hex_val};
						mode_d = MODE_HEX;
					end else begin
						cmd.amp = 1'b1;
						cmd.hash = 1'b1;
						cmd.hexx = 1'b1;
						mode_d = MODE_IDLE;
						do_fresh = 1'b1;
					end
				end
				MODE_DEC, MODE_HEX: begin
					if ((mode_q == MODE_DEC && is_digit) || (mode_q == MODE_HEX && is_hex)) begin
						acc_d = acc_next;
					end else begin
						cmd.ref_en = 1'b1;
						cmd.ref_hex = (mode_q == MODE_HEX);
						cmd.code = acc_q;
						mode_d = MODE_IDLE;
						acc_d = '0;
						do_fresh = (in_byte != CH_SEMI);
					end
				end
				default: begin
					mode_d = MODE_IDLE;
					do_fresh = 1'b1;
				end
			endcase
			if (do_fresh) begin
				if (in_byte == CH_AMP) begin
					mode_d = MODE_AMP;
				end else begin
					cmd.fresh_en = 1'b1;
					cmd.fresh = in_byte;
				end
			end
		end
	end

	assign push = accept && (cmd.amp_plain || cmd.amp || cmd.ref_en || cmd.fresh_en);
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			acc_q <= acc_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/ncr_queue.sv =====
`default_nettype none
module ncr_queue import ncr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire cmd_t push_cmd,
	input wire logic pop,
	output logic full,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t entries_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign full = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/ncr_back.sv =====
`default_nettype none
module ncr_back import ncr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic keep_builtin_refs,
	input wire logic escape_lone_ampersand,
	input wire logic head_valid,
	input wire cmd_t head_cmd,
	output logic pop,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] out_byte,
	output logic last_of_run
);

	logic [7:0] buf_q [8];
	logic [3:0] len_q;
	logic [2:0] idx_q;
	logic busy_q;

	logic [7:0] bytes [8];
	logic [3:0] n;
	logic take, done;

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		return (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h57 + {4'd0, d});
	endfunction

	always_comb begin
		logic [CODE_W-1:0] code;
		logic builtin;
		logic [2:0] tail;
		logic [7:0] lead;
		code = head_cmd.code;
		builtin = (code == 31'd38) || (code == 31'd39) || (code == 31'd34)
			|| (code == 31'd60) || (code == 31'd62);
		tail = 3'd0;
		lead = code[7:0];
		for (int k = 0; k < 8; k++) begin
			bytes[k] = 8'h00;
		end
		n = 4'd0;
		if (head_cmd.amp_plain) begin
			bytes[n[2:0]] = CH_AMP;
			n = n + 4'd1;
		end
		if (head_cmd.amp) begin
			bytes[n[2:0]] = CH_AMP;
			n = n + 4'd1;
			if (escape_lone_ampersand) begin
				bytes[n[2:0]] = 8'h61;
				bytes[n[2:0] + 3'd1] = 8'h6d;
				bytes[n[2:0] + 3'd2] = 8'h70;
				bytes[n[2:0] + 3'd3] = CH_SEMI;
				n = n + 4'd4;
			end
		end
		if (head_cmd.hash) begin
			bytes[n[2:0]] = CH_HASH;
			n = n + 4'd1;
		end
		if (head_cmd.hexx) begin
			bytes[n[2:0]] = CH_X;
			n = n + 4'd1;
		end
		if (head_cmd.ref_en) begin
			if (keep_builtin_refs && builtin) begin
				bytes[0] = CH_AMP;
				bytes[1] = CH_HASH;
				if (head_cmd.ref_hex) begin
					bytes[2] = CH_X;
					bytes[3] = hex_char(code[7:4]);
					bytes[4] = hex_char(code[3:0]);
					bytes[5] = CH_SEMI;
					n = 4'd6;
				end else begin
					case (code[5:0])
						6'd34: begin
							bytes[2] = 8'h33;
							bytes[3] = 8'h34;
						end
						6'd38: begin
							bytes[2] = 8'h33;
							bytes[3] = 8'h38;
						end
						6'd39: begin
							bytes[2] = 8'h33;
							bytes[3] = 8'h39;
						end
						6'd60: begin
							bytes[2] = 8'h36;
							bytes[3] = 8'h30;
						end
						default: begin
							bytes[2] = 8'h36;
							bytes[3] = 8'h32;
						end
					endcase
					bytes[4] = CH_SEMI;
					n = 4'd5;
				end
			end else begin
				if (code <= 31'h7F) begin
					tail = 3'd0;
					lead = code[7:0];
				end else if (code <= 31'h7FF) begin
					tail = 3'd1;
					lead = 8'hC0 | {3'b000, code[10:6]};
				end else if (code <= 31'hFFFF) begin
					tail = 3'd2;
					lead = 8'hE0 | {4'b0000, code[15:12]};
				end else if (code <= 31'h1FFFFF) begin
					tail = 3'd3;
					lead = 8'hF0 | {5'b00000, code[20:18]};
				end else if (code <= 31'h3FFFFFF) begin
					tail = 3'd4;
					lead = 8'hF8 | {6'b000000, code[25:24]};
				end else begin
					tail = 3'd5;
					lead = 8'hFC | {7'b0000000, code[30]};
				end
				bytes[0] = lead;
				n = 4'd1;
				for (int i = 4; i >= 0; i--) begin
					if (i < int'(tail)) begin
						bytes[n[2:0]] = 8'h80 | {2'b00, code[6*i +: 6]};
						n = n + 4'd1;
					end
				end
			end
		end
		if (head_cmd.fresh_en) begin
			bytes[n[2:0]] = head_cmd.fresh;
			n = n + 4'd1;
		end
	end

	assign out_valid = busy_q;
	assign out_byte = buf_q[idx_q];
	assign last_of_run = ({1'b0, idx_q} == (len_q - 4'd1));
	assign take = busy_q && !out_stall;
	assign done = take && last_of_run;
	assign pop = head_valid && (!busy_q || done);

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int k = 0; k < 8; k++) begin
				buf_q[k] <= bytes[k];
			end
			len_q <= n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (take) begin
			idx_q <= idx_q + 3'd1;
		end
	end

endmodule
`default_nettype wire

// ===== src/numeric_char_ref_to_utf8.sv =====
// Channel  | Handshake            | Payload
// input    | in_valid, in_stall   | in_byte, end_of_stream
// output   | out_valid, out_stall | out_byte, last_of_run
// config   | cfg_we               | cfg_index, cfg_data
//
// The front end takes one input byte per cycle while its four-entry request queue has room.
// The back end writes one output byte per cycle while out_stall is low, and an input byte
// expands to 0 to 8 output bytes; each request is registered in the queue and then in the
// back end's byte buffer before its first byte is valid.
// Reset clears the parse mode, the accumulator, the queue and both configuration registers.
// A stalled output holds its byte; the queue then fills and raises in_stall.
`default_nettype none
module numeric_char_ref_to_utf8 import ncr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] in_byte,
	input wire logic end_of_stream,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] out_byte,
	output logic last_of_run
);

	logic keep_builtin_refs_q;
	logic escape_lone_ampersand_q;
	logic accept;
	logic push;
	cmd_t push_cmd;
	logic full;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_builtin_refs_q <= 1'b0;
			escape_lone_ampersand_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_KEEP_BUILTIN) begin
				keep_builtin_refs_q <= cfg_data[0];
			end
			if (cfg_index == REG_ESCAPE_AMP) begin
				escape_lone_ampersand_q <= cfg_data[0];
			end
		end
	end

	assign in_stall = full;
	assign accept = in_valid && !full;

	ncr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.in_byte(in_byte),
		.end_of_stream(end_of_stream),
		.push(push),
		.push_cmd(push_cmd)
	);

	ncr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.pop(pop),
		.full(full),
		.head_valid(head_valid),
		.head_cmd(head_cmd)
	);

	ncr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.keep_builtin_refs(keep_builtin_refs_q),
		.escape_lone_ampersand(escape_lone_ampersand_q),
		.head_valid(head_valid),
		.head_cmd(head_cmd),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.last_of_run(last_of_run)
	);

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
module testbench;
	import ncr_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_AMP, ST_HASH, ST_HEXX, ST_DEC, ST_HEX} parse_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic last;
	} beat_t;

	typedef struct {
		logic [7:0] data;
		logic eos;
	} in_item_t;

	class utf8_expansion_check;
		parse_state_t state;
		logic [30:0] code;
		logic keep_builtin;
		logic escape_amp;
		beat_t expected_bytes[$];
		int errors;

		function new();
			state = ST_IDLE;
			code = '0;
			keep_builtin = 1'b0;
			escape_amp = 1'b0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_KEEP_BUILTIN) begin
				keep_builtin = val[0];
			end else if (idx == REG_ESCAPE_AMP) begin
				escape_amp = val[0];
			end
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		function void put(logic [7:0] b);
			expected_bytes.push_back('{b, 1'b0});
		endfunction

		function void put_amp();
			put(CH_AMP);
			if (escape_amp) begin
				put("a");
				put("m");
				put("p");
				put(CH_SEMI);
			end
		endfunction

		function void put_utf8(logic [30:0] n);
			int tail;
			logic [30:0] t;
			if (n <= 31'h7F) begin
				put(n[7:0]);
				return;
			end else if (n <= 31'h7FF) begin
				put({3'b110, n[10:6]});
				tail = 1;
			end else if (n <= 31'hFFFF) begin
				put({4'b1110, n[15:12]});
				tail = 2;
			end else if (n <= 31'h1FFFFF) begin
				put({5'b11110, n[20:18]});
				tail = 3;
			end else if (n <= 31'h3FFFFFF) begin
				put({6'b111110, n[25:24]});
				tail = 4;
			end else begin
				put({7'b1111110, n[30]});
				tail = 5;
			end
			for (int i = tail - 1; i >= 0; i--) begin
				t = n >> (6 * i);
				put({2'b10, t[5:0]});
			end
		endfunction

		function logic [7:0] lower_hex(logic [3:0] v);
			return (v < 10) ? 8'h30 + v : 8'h57 + v;
		endfunction

		function void finish_code(logic hex);
			if (keep_builtin && (code == 34 || code == 38 || code == 39 || code == 60 ||
					code == 62)) begin
				put(CH_AMP);
				put(CH_HASH);
				if (hex) begin
					put(CH_X);
					put(lower_hex(code[7:4]));
					put(lower_hex(code[3:0]));
				end else begin
					put(8'h30 + code[7:0] / 8'd10);
					put(8'h30 + code[7:0] % 8'd10);
				end
				put(CH_SEMI);
			end else begin
				put_utf8(code);
			end
		endfunction

		function logic is_digit(logic [7:0] c);
			return c >= 8'h30 && c <= 8'h39;
		endfunction

		function logic is_alnum(logic [7:0] c);
			return is_digit(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
		endfunction

		function logic is_hex(logic [7:0] c);
			return is_digit(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
		endfunction

		function logic [7:0] hex_val(logic [7:0] c);
			if (c <= 8'h39) return c - 8'h30;
			else if (c <= 8'h46) return c - 8'h37;
			else return c - 8'h57;
		endfunction

		function logic [30:0] accumulate(int base, logic [7:0] digit);
			logic [63:0] v;
			v = {33'd0, code} * 64'(base) + 64'(digit);
			return (v > 64'h7FFFFFFF) ? 31'h7FFFFFFF : v[30:0];
		endfunction

		function void fresh(logic [7:0] c);
			if (c == CH_AMP) state = ST_AMP;
			else put(c);
		endfunction

		function void take_request(logic [7:0] c, logic eos);
			int first_new;
			logic hex;
			first_new = expected_bytes.size();
			hex = (state == ST_HEX);
			if (eos) begin
				case (state)
					ST_AMP: put_amp();
					ST_HASH: begin
						put_amp();
						put(CH_HASH);
					end
					ST_HEXX: begin
						put_amp();
						put(CH_HASH);
						put(CH_X);
					end
					ST_DEC, ST_HEX: finish_code(hex);
					default: ;
				endcase
				state = ST_IDLE;
				code = '0;
			end else begin
				case (state)
					ST_AMP: begin
						if (c == CH_HASH) begin
							state = ST_HASH;
						end else begin
							if (is_alnum(c)) put(CH_AMP);
							else put_amp();
							state = ST_IDLE;
							fresh(c);
						end
					end
					ST_HASH: begin
						if (is_digit(c)) begin
							code = 31'(c - 8'h30);
							state = ST_DEC;
						end else if (c == CH_X) begin
							state = ST_HEXX;
						end else begin
							put_amp();
							put(CH_HASH);
							state = ST_IDLE;
							fresh(c);
						end
					end
					ST_HEXX: begin
						if (is_hex(c)) begin
							code = 31'(hex_val(c));
							state = ST_HEX;
						end else begin
							put_amp();
							put(CH_HASH);
							put(CH_X);
							state = ST_IDLE;
							fresh(c);
						end
					end
					ST_DEC, ST_HEX: begin
						if (!hex && is_digit(c)) begin
							code = accumulate(10, c - 8'h30);
						end else if (hex && is_hex(c)) begin
							code = accumulate(16, hex_val(c));
						end else begin
							finish_code(hex);
							state = ST_IDLE;
							code = '0;
							if (c != CH_SEMI) fresh(c);
						end
					end
					default: begin
						state = ST_IDLE;
						fresh(c);
					end
				endcase
			end
			if (expected_bytes.size() > first_new)
				expected_bytes[expected_bytes.size() - 1].last = 1'b1;
		endfunction

		function void check_byte(logic [7:0] got, logic got_last);
			beat_t want;
			if (expected_bytes.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected output byte %02h last %b at %0t", got, got_last, $time);
			end else begin
				want = expected_bytes.pop_front();
				if (want.data !== got || want.last !== got_last) begin
					errors++;
					if (errors <= 10)
						$display("output byte: expected %02h last %b, got %02h last %b at %0t",
							want.data, want.last, got, got_last, $time);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] in_byte = '0;
	logic end_of_stream = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_byte;
	logic last_of_run;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	in_item_t text_q[$];
	utf8_expansion_check expansion = new();

	numeric_char_ref_to_utf8 DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.end_of_stream(end_of_stream),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("numeric_char_ref_to_utf8: mismatch");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			expansion.check_byte(out_byte, last_of_run);
		out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
	end

	function automatic void push_byte(logic [7:0] b);
		text_q.push_back('{b, 1'b0});
	endfunction

	function automatic void push_eos();
		text_q.push_back('{8'($urandom_range(0, 255)), 1'b1});
	endfunction

	function automatic void push_text(string s);
		foreach (s[i])
			push_byte(s[i]);
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] v, logic upper);
		if (v < 10) return 8'h30 + v;
		return (upper ? 8'h37 : 8'h57) + v;
	endfunction

	function automatic void push_dec(logic [30:0] n);
		logic [7:0] digs[$];
		do begin
			digs.push_front(8'h30 + 8'(n % 10));
			n = 31'(n / 10);
		end while (n != 0);
		if ($urandom_range(0, 3) == 0) digs.push_front(8'h30);
		foreach (digs[i])
			push_byte(digs[i]);
	endfunction

	function automatic void push_hex(logic [30:0] n);
		logic [7:0] digs[$];
		do begin
			digs.push_front(hex_char(n[3:0], 1'($urandom_range(0, 1))));
			n = n >> 4;
		end while (n != 0);
		if ($urandom_range(0, 3) == 0) digs.push_front(8'h30);
		foreach (digs[i])
			push_byte(digs[i]);
	endfunction

	// Mostly well-formed references spread over every UTF-8 length, the rest broken
	// prefixes, loose bytes and flushes.
	function automatic void make_chunk();
		int kind;
		int sel;
		logic hex;
		logic [30:0] n;
		logic [7:0] builtin_codes [5] = '{8'd34, 8'd38, 8'd39, 8'd60, 8'd62};
		kind = $urandom_range(0, 99);
		hex = 1'($urandom_range(0, 1));
		n = '0;
		if (kind < 55) begin
			push_text("&#");
			if (hex) push_byte(CH_X);
			sel = $urandom_range(0, 7);
			case (sel)
				0: n = 31'($urandom_range(32'h7F, 0));
				1: n = 31'($urandom_range(32'h7FF, 32'h80));
				2: n = 31'($urandom_range(32'hFFFF, 32'h800));
				3: n = 31'($urandom_range(32'h1FFFFF, 32'h10000));
				4: n = 31'($urandom_range(32'h3FFFFFF, 32'h200000));
				5: n = 31'($urandom_range(32'h7FFFFFFF, 32'h4000000));
				6: n = 31'(builtin_codes[$urandom_range(0, 4)]);
				default: ;
			endcase
			if (sel == 7) begin
				repeat ($urandom_range(9, 13)) begin
					if (hex) push_byte(hex_char(4'($urandom_range(1, 15)),
						1'($urandom_range(0, 1))));
					else push_byte(8'h30 + 8'($urandom_range(1, 9)));
				end
			end else if (hex) begin
				push_hex(n);
			end else begin
				push_dec(n);
			end
			sel = $urandom_range(0, 9);
			if (sel < 6) push_byte(CH_SEMI);
			else if (sel < 9) push_byte(8'($urandom_range(0, 255)));
			else push_eos();
		end else if (kind < 70) begin
			push_byte(CH_AMP);
			sel = $urandom_range(0, 2);
			if (sel > 0) push_byte(CH_HASH);
			if (sel > 1) push_byte(CH_X);
			if ($urandom_range(0, 4) == 0) push_eos();
			else push_byte(8'($urandom_range(0, 255)));
		end else if (kind < 93) begin
			push_byte(8'($urandom_range(0, 255)));
		end else begin
			push_eos();
		end
	endfunction

	task automatic send_item(input logic [7:0] b, input logic e);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_stream <= e;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expansion.take_request(b, e);
	endtask

	task automatic send_queued();
		in_item_t it;
		while (text_q.size() != 0) begin
			it = text_q.pop_front();
			send_item(it.data, it.eos);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expansion.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_regs(input logic keep, input logic esc);
		cfg_we <= 1'b1;
		cfg_index <= REG_KEEP_BUILTIN;
		cfg_data <= keep;
		@(posedge clk);
		expansion.set_reg(REG_KEEP_BUILTIN, keep);
		cfg_index <= REG_ESCAPE_AMP;
		cfg_data <= esc;
		@(posedge clk);
		expansion.set_reg(REG_ESCAPE_AMP, esc);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int send_pct [6] = '{24, 24, 73, 73, 0, 0};
		int recv_pct [6] = '{73, 73, 24, 24, 0, 0};
		logic keep_set [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
		logic esc_set [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
		int count_set [6] = '{38, 38, 38, 38, 42, 42};
		int sent;
		in_item_t it;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < 6; p++) begin
			send_idle_pct = send_pct[p];
			recv_stall_pct = recv_pct[p];
			write_regs(keep_set[p], esc_set[p]);
			if (p == 0) begin
				push_text("&#0;&#x26Z&a&#q&#x");
				push_eos();
				push_byte(8'h00);
				push_byte(8'hFF);
				push_text("&#12");
				push_eos();
				send_queued();
			end
			sent = 0;
			while (sent < count_set[p]) begin
				make_chunk();
				while (text_q.size() != 0) begin
					it = text_q.pop_front();
					send_item(it.data, it.eos);
					sent++;
					if (p == 2 && sent == 20)
						wait_drained();
				end
			end
			// Close any open reference so the register writes land on an idle parser.
			push_eos();
			send_queued();
			wait_drained();
			repeat (16) @(posedge clk);
		end
		if (expansion.errors == 0 && expansion.pending() == 0)
			$display("numeric_char_ref_to_utf8: match");
		else
			$display("numeric_char_ref_to_utf8: mismatch");
		$finish;
	end

endmodule
